### design/srts_pkg.sv
// Shared constants, status codes and controller/datapath interface types
// for the shortest-remaining-time scheduler. No dependencies.
package srts_pkg;

    // Table depth and the widths that follow from it.
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Fixed field widths of the item channels.
    localparam int IN_T_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 40;
    localparam int PID_W   = 4;
    localparam int DONE_W  = 5;
    localparam int STAT_W  = 3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_LOADED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_RAN      = 3'd2;
    localparam logic [STAT_W-1:0] ST_IDLE     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ALL_DONE = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;       // write a new process into the tables
        logic refuse;     // report a refused load
        logic all_done;   // report an all-done tick
        logic scan_clr;   // start a selection scan
        logic scan_step;  // read the next table entry
        logic eval;       // run the chosen process, advance time
        logic wt;         // form waiting time
        logic acc;        // add to the running totals
        logic out_load;   // copy the result into the output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic full;       // table holds MAX_PROCS processes
        logic bst_zero;   // offered burst is zero
        logic all_done;   // every loaded process has completed
        logic scan_last;  // entry being read is the last loaded one
    } t_sts;

endpackage

### design/srts_ctrl.sv
// Controller state machine of the shortest-remaining-time scheduler.
// Depends on srts_pkg for the command and status types.
module srts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_mode,
    input  logic           i_out_stall,
    input  srts_pkg::t_sts i_sts,
    output srts_pkg::t_cmd o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);
    import srts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EVAL,
        S_WT,
        S_ACC,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_out_vld = r_out_vld && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (!i_mode) begin
                        if (i_sts.full || i_sts.bst_zero) begin
                            o_cmd.refuse = 1'b1;
                        end else begin
                            o_cmd.load = 1'b1;
                        end
                        n_state = S_DONE;
                    end else if (i_sts.all_done) begin
                        o_cmd.all_done = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_WT;
            end
            S_WT: begin
                o_cmd.wt = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

### design/srts_dp.sv
// Datapath of the shortest-remaining-time scheduler: process tables,
// selection scan, time and totals, result and output registers. Uses srts_pkg.
module srts_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  srts_pkg::t_cmd                 i_cmd,
    input  logic [srts_pkg::IN_T_W-1:0]    i_arrival_time,
    input  logic [srts_pkg::IN_T_W-1:0]    i_burst_time,
    output srts_pkg::t_sts                 o_sts,
    output logic [srts_pkg::STAT_W-1:0]    o_status,
    output logic [srts_pkg::PID_W-1:0]     o_process_id,
    output logic [srts_pkg::TIME_W-1:0]    o_time_now,
    output logic                           o_finished,
    output logic [srts_pkg::TIME_W-1:0]    o_completion_time,
    output logic [srts_pkg::TIME_W-1:0]    o_turnaround,
    output logic [srts_pkg::TIME_W-1:0]    o_waiting,
    output logic [srts_pkg::DONE_W-1:0]    o_done_count,
    output logic [srts_pkg::SUM_W-1:0]     o_total_turnaround,
    output logic [srts_pkg::SUM_W-1:0]     o_total_waiting
);
    import srts_pkg::*;

    // Process tables, one write and one read port each.
    logic [IN_T_W-1:0] r_arr_mem [MAX_PROCS];
    logic [IN_T_W-1:0] r_bst_mem [MAX_PROCS];
    logic [IN_T_W-1:0] r_rem_mem [MAX_PROCS];

    logic [CNT_W-1:0]  r_lc;
    logic [CNT_W-1:0]  r_cc;
    logic [TIME_W-1:0] r_time;
    logic [SUM_W-1:0]  r_tsum;
    logic [SUM_W-1:0]  r_wsum;

    // Scan state.
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    logic [IN_T_W-1:0] r_rd_arr;
    logic [IN_T_W-1:0] r_rd_bst;
    logic [IN_T_W-1:0] r_rd_rem;
    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IN_T_W-1:0] r_best_arr;
    logic [IN_T_W-1:0] r_best_bst;
    logic [IN_T_W-1:0] r_best_rem;

    // Result being built.
    logic [STAT_W-1:0] r_res_status;
    logic [PID_W-1:0]  r_res_pid;
    logic              r_res_fin;
    logic [TIME_W-1:0] r_res_ct;
    logic [TIME_W-1:0] r_res_tat;
    logic [TIME_W-1:0] r_res_wt;

    // Output register.
    logic [STAT_W-1:0] r_o_status;
    logic [PID_W-1:0]  r_o_pid;
    logic [TIME_W-1:0] r_o_time;
    logic              r_o_fin;
    logic [TIME_W-1:0] r_o_ct;
    logic [TIME_W-1:0] r_o_tat;
    logic [TIME_W-1:0] r_o_wt;
    logic [CNT_W-1:0]  r_o_done;
    logic [SUM_W-1:0]  r_o_tsum;
    logic [SUM_W-1:0]  r_o_wsum;

    logic              w_cand;
    logic              w_better;
    logic [TIME_W-1:0] w_time_inc;
    logic [TIME_W-1:0] w_bst_ext;
    logic [SUM_W:0]    w_tsum_add;
    logic [SUM_W:0]    w_wsum_add;
    logic [IN_T_W-1:0] w_rem_dec;

    assign o_sts.full      = (r_lc == CNT_W'(MAX_PROCS));
    assign o_sts.bst_zero  = (i_burst_time == '0);
    assign o_sts.all_done  = (r_cc >= r_lc);
    assign o_sts.scan_last = (CNT_W'(r_idx) == (r_lc - CNT_W'(1)));

    assign w_cand   = r_rd_vld && (TIME_W'(r_rd_arr) <= r_time) && (r_rd_rem != '0);
    assign w_better = !r_found || (r_rd_rem < r_best_rem) ||
                      ((r_rd_rem == r_best_rem) && (r_rd_arr < r_best_arr));

    assign w_time_inc = (r_time == '1) ? r_time : (r_time + TIME_W'(1));
    assign w_rem_dec  = r_best_rem - IN_T_W'(1);
    assign w_bst_ext  = TIME_W'(r_best_bst);
    assign w_tsum_add = {1'b0, r_tsum} + (SUM_W + 1)'(r_res_tat);
    assign w_wsum_add = {1'b0, r_wsum} + (SUM_W + 1)'(r_res_wt);

    // Table memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_arr_mem[r_lc[IDX_W-1:0]] <= i_arrival_time;
            r_bst_mem[r_lc[IDX_W-1:0]] <= i_burst_time;
            r_rem_mem[r_lc[IDX_W-1:0]] <= i_burst_time;
        end else if (i_cmd.eval && r_found) begin
            r_rem_mem[r_best_idx] <= w_rem_dec;
        end
        r_rd_arr <= r_arr_mem[r_idx];
        r_rd_bst <= r_bst_mem[r_idx];
        r_rd_rem <= r_rem_mem[r_idx];
    end

    // Control state: counts, time, totals, scan flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc     <= '0;
            r_cc     <= '0;
            r_time   <= '0;
            r_tsum   <= '0;
            r_wsum   <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.load) begin
                r_lc <= r_lc + CNT_W'(1);
            end
            if (i_cmd.scan_clr) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (w_cand) begin
                r_found <= 1'b1;
            end
            if (i_cmd.eval) begin
                r_time <= w_time_inc;
                if (r_found && (r_best_rem == IN_T_W'(1))) begin
                    r_cc <= r_cc + CNT_W'(1);
                end
            end
            if (i_cmd.acc && r_res_fin) begin
                r_tsum <= w_tsum_add[SUM_W] ? '1 : w_tsum_add[SUM_W-1:0];
                r_wsum <= w_wsum_add[SUM_W] ? '1 : w_wsum_add[SUM_W-1:0];
            end
        end
    end

    // Payload: read tracking, best candidate, result, output register.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (w_cand && w_better) begin
            r_best_idx <= r_rd_idx;
            r_best_arr <= r_rd_arr;
            r_best_bst <= r_rd_bst;
            r_best_rem <= r_rd_rem;
        end
        if (i_cmd.load) begin
            r_res_status <= ST_LOADED;
            r_res_pid    <= PID_W'(r_lc);
            r_res_fin    <= 1'b0;
            r_res_ct     <= '0;
            r_res_tat    <= '0;
            r_res_wt     <= '0;
        end else if (i_cmd.refuse || i_cmd.all_done) begin
            r_res_status <= i_cmd.refuse ? ST_REFUSED : ST_ALL_DONE;
            r_res_pid    <= '0;
            r_res_fin    <= 1'b0;
            r_res_ct     <= '0;
            r_res_tat    <= '0;
            r_res_wt     <= '0;
        end else if (i_cmd.eval) begin
            r_res_wt <= '0;
            if (r_found) begin
                r_res_status <= ST_RAN;
                r_res_pid    <= PID_W'(r_best_idx);
                if (r_best_rem == IN_T_W'(1)) begin
                    r_res_fin <= 1'b1;
                    r_res_ct  <= w_time_inc;
                    r_res_tat <= w_time_inc - TIME_W'(r_best_arr);
                end else begin
                    r_res_fin <= 1'b0;
                    r_res_ct  <= '0;
                    r_res_tat <= '0;
                end
            end else begin
                r_res_status <= ST_IDLE;
                r_res_pid    <= '0;
                r_res_fin    <= 1'b0;
                r_res_ct     <= '0;
                r_res_tat    <= '0;
            end
        end else if (i_cmd.wt && r_res_fin) begin
            r_res_wt <= (r_res_tat >= w_bst_ext) ? (r_res_tat - w_bst_ext) : '0;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_pid    <= r_res_pid;
            r_o_time   <= r_time;
            r_o_fin    <= r_res_fin;
            r_o_ct     <= r_res_ct;
            r_o_tat    <= r_res_tat;
            r_o_wt     <= r_res_wt;
            r_o_done   <= r_cc;
            r_o_tsum   <= r_tsum;
            r_o_wsum   <= r_wsum;
        end
    end

    assign o_status           = r_o_status;
    assign o_process_id       = r_o_pid;
    assign o_time_now         = r_o_time;
    assign o_finished         = r_o_fin;
    assign o_completion_time  = r_o_ct;
    assign o_turnaround       = r_o_tat;
    assign o_waiting          = r_o_wt;
    assign o_done_count       = DONE_W'(r_o_done);
    assign o_total_turnaround = r_o_tsum;
    assign o_total_waiting    = r_o_wsum;

endmodule

### design/shortest_remaining_time_scheduler_unit.sv
// Top level of the shortest-remaining-time scheduler.
// Joins srts_ctrl and srts_dp; uses srts_pkg for widths and types.
//
// Input channel (i_in_valid / o_in_stall): one item either loads a process
// (i_mode = 0, arrival and burst given) or is a tick (i_mode = 1) that
// advances time by one unless every loaded process is done. Output channel
// (o_out_valid / i_out_stall): exactly one result item per input item, in order.
// A load is written into the result register when it is accepted and is
// then handed over. A tick first runs the selection scan, which reads one
// table entry per cycle through the single read port of the process tables;
// a drain state then lets the last read land, the evaluate, waiting-time and
// totals steps follow in turn, and a final state hands the result over. An
// all-done tick or a refused load is handed over as a load is.
// One item is in work at a time; o_in_stall is high while it is.
// Results wait in an output register: the next item is accepted while a result
// waits, and the block holds its finished next result until the register
// frees. A stall on the output therefore backs up into o_in_stall after one item.
// Reset (i_rst_n low, synchronous) empties the table, zeroes time, counts and
// totals, and drops any pending result.
module shortest_remaining_time_scheduler_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [srts_pkg::IN_T_W-1:0]    i_arrival_time,
    input  logic [srts_pkg::IN_T_W-1:0]    i_burst_time,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [srts_pkg::STAT_W-1:0]    o_status,
    output logic [srts_pkg::PID_W-1:0]     o_process_id,
    output logic [srts_pkg::TIME_W-1:0]    o_time_now,
    output logic                           o_finished,
    output logic [srts_pkg::TIME_W-1:0]    o_completion_time,
    output logic [srts_pkg::TIME_W-1:0]    o_turnaround,
    output logic [srts_pkg::TIME_W-1:0]    o_waiting,
    output logic [srts_pkg::DONE_W-1:0]    o_done_count,
    output logic [srts_pkg::SUM_W-1:0]     o_total_turnaround,
    output logic [srts_pkg::SUM_W-1:0]     o_total_waiting
);
    import srts_pkg::*;

    // Command and status between sequencer and datapath.
    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence each item: decide load, refuse or tick, step the scan, and
    // hand the result to the output register when it is free.
    srts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Hold the tables, scan for the least remaining time, advance time and
    // keep the saturating totals.
    srts_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .o_sts              (w_sts),
        .o_status           (o_status),
        .o_process_id       (o_process_id),
        .o_time_now         (o_time_now),
        .o_finished         (o_finished),
        .o_completion_time  (o_completion_time),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_done_count       (o_done_count),
        .o_total_turnaround (o_total_turnaround),
        .o_total_waiting    (o_total_waiting)
    );

endmodule
